### design/fpa_pkg.sv
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_CMP      = 4'd4,
    OP_MIN      = 4'd5,
    OP_MAX      = 4'd6,
    OP_INC      = 4'd7,
    OP_DEC      = 4'd8,
    OP_TO_INT   = 4'd9,
    OP_FROM_INT = 4'd10
  } op_t;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               less;
    logic               equal;
    logic               greater;
    logic               overflow;
    logic               div_by_zero;
  } result_t;

endpackage

### design/fpa_if.sv
interface fpa_req_if;
  import fpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [3:0]         op;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, op, operand_a, operand_b, input ready);
  modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

interface fpa_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               less;
  logic               equal;
  logic               greater;
  logic               overflow;
  logic               div_by_zero;
  modport source (output valid, value, less, equal, greater, overflow, div_by_zero,
                  input ready);
  modport sink   (input valid, value, less, equal, greater, overflow, div_by_zero,
                  output ready);
endinterface

### design/fpa_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, each stage registered.
// Holds its contents while en is low. The valid bit of each stage is cleared by reset.
module fpa_div_pipe import fpa_pkg::*; #(
  parameter int NW = 40,
  parameter int DW = 32,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          v_in,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic [NW-1:0] quo,
  output logic [DW:0]   rem,
  output logic [DW-1:0] den_out,
  output logic          v_out,
  output logic [TW-1:0] tag_out
);

  logic [NW-1:0] q_s [NW+1];
  logic [DW:0]   r_s [NW+1];
  logic [DW-1:0] d_s [NW+1];
  logic [TW-1:0] t_s [NW+1];
  logic          v_s [NW+1];

  assign q_s[0] = num;
  assign r_s[0] = '0;
  assign d_s[0] = den;
  assign t_s[0] = tag_in;
  assign v_s[0] = v_in;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW+1:0] sh;
    logic [DW+1:0] diff;
    logic [NW-1:0] q_nx;
    logic [DW:0]   r_nx;
    always_comb begin
      sh   = {r_s[i], q_s[i][NW-1]};
      diff = sh - {2'b00, d_s[i]};
      if (!diff[DW+1]) begin
        r_nx = diff[DW:0];
        q_nx = {q_s[i][NW-2:0], 1'b1};
      end else begin
        r_nx = sh[DW:0];
        q_nx = {q_s[i][NW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v_s[i+1] <= 1'b0;
      else if (en) v_s[i+1] <= v_s[i];
      if (en) begin
        q_s[i+1] <= q_nx;
        r_s[i+1] <= r_nx;
        d_s[i+1] <= d_s[i];
        t_s[i+1] <= t_s[i];
      end
    end
  end

  assign quo     = q_s[NW];
  assign rem     = r_s[NW];
  assign den_out = d_s[NW];
  assign v_out   = v_s[NW];
  assign tag_out = t_s[NW];

endmodule

### design/fixed_point_alu.sv
// Signed fixed-point ALU, Q(31-FRACTION_BITS).FRACTION_BITS, on 32-bit raw values.
// Requests arrive on the req channel (op, operand_a, operand_b) and each one
// yields exactly one result on the res channel (value and five flags).
// Every request walks the same pipeline so results leave in request order.
// The stages are: operand decode and magnitudes, a 32x32 multiply beside a
// bit-per-stage divider, rounding, then sign and saturation into the output.
// There are FRACTION_BITS + 36 register stages (44 at the default), set by the
// divider, which produces one quotient bit per stage over 32+FRACTION_BITS
// stages. Throughput is one request per cycle while the receiver takes results.
// The whole pipeline advances together: it moves whenever the output register
// is empty or being taken this cycle. When the receiver stalls with a result
// waiting, the pipeline freezes in place and req.ready drops, so nothing is
// lost or repeated; ready returns the cycle the receiver takes the result.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// Divide by zero saturates by the dividend sign (zero for 0/0) and flags it.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  fpa_req_if.sink   req,
  fpa_res_if.source res
);

  localparam int NW    = 32 + FRACTION_BITS;

  logic adv;
  logic out_valid;
  result_t out_reg;

  assign adv       = !out_valid || res.ready;
  assign req.ready = adv;

  // Stage 1: decode, magnitudes, simple ops.
  typedef struct packed {
    logic [3:0]  op;
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    result_t     simple;
    logic        a_sign;
    logic        a_zero;
  } s1_t;

  s1_t s1, s1_next;
  logic s1_v;

  always_comb begin
    logic signed [32:0] ax, bx, sum;
    logic signed [63:0] sh;
    s1_next = '0;
    ax = {req.operand_a[31], req.operand_a};
    bx = {req.operand_b[31], req.operand_b};
    sum = '0;
    sh  = '0;
    s1_next.op     = req.op;
    s1_next.neg    = req.operand_a[31] ^ req.operand_b[31];
    s1_next.ma     = req.operand_a[31] ? 32'(-req.operand_a) : req.operand_a;
    s1_next.mb     = req.operand_b[31] ? 32'(-req.operand_b) : req.operand_b;
    s1_next.a_sign = req.operand_a[31];
    s1_next.a_zero = (req.operand_a == '0);
    case (op_t'(req.op))
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        case (op_t'(req.op))
          OP_ADD:  sum = ax + bx;
          OP_SUB:  sum = ax - bx;
          OP_INC:  sum = ax + 33'sd1;
          default: sum = ax - 33'sd1;
        endcase
        if (sum[32] != sum[31]) begin
          s1_next.simple.overflow = 1'b1;
          s1_next.simple.value    = sum[32] ? VAL_MIN : VAL_MAX;
        end else begin
          s1_next.simple.value = sum[31:0];
        end
      end
      OP_CMP: begin
        s1_next.simple.less    = req.operand_a < req.operand_b;
        s1_next.simple.equal   = req.operand_a == req.operand_b;
        s1_next.simple.greater = req.operand_a > req.operand_b;
      end
      OP_MIN: s1_next.simple.value =
                (req.operand_a < req.operand_b) ? req.operand_a : req.operand_b;
      OP_MAX: s1_next.simple.value =
                (req.operand_a > req.operand_b) ? req.operand_a : req.operand_b;
      OP_TO_INT: s1_next.simple.value = req.operand_a >>> FRACTION_BITS;
      OP_FROM_INT: begin
        sh = 64'(signed'(req.operand_a)) <<< FRACTION_BITS;
        if (sh > 64'(signed'(VAL_MAX))) begin
          s1_next.simple.value = VAL_MAX; s1_next.simple.overflow = 1'b1;
        end else if (sh < 64'(signed'(VAL_MIN))) begin
          s1_next.simple.value = VAL_MIN; s1_next.simple.overflow = 1'b1;
        end else begin
          s1_next.simple.value = sh[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= req.valid;
    if (adv) s1 <= s1_next;
  end

  // Tag carried alongside the divider.
  typedef struct packed {
    logic        v;
    logic [3:0]  op;
    logic        neg;
    logic        a_sign;
    logic        a_zero;
    logic        b_zero;
    result_t     simple;
    logic [63:0] prod;
  } tag_t;

  // The multiply product is registered once, then rides in the tag.
  tag_t tag_in, tag_out, tag_mul;
  logic [NW-1:0] num;
  logic [31:0]   den_out;
  logic [NW-1:0] quo;
  logic [32:0]   rem;
  logic          div_v;

  always_ff @(posedge clk) begin
    if (rst) tag_mul.v <= 1'b0;
    else if (adv) tag_mul.v <= s1_v;
    if (adv) begin
      tag_mul.op     <= s1.op;
      tag_mul.neg    <= s1.neg;
      tag_mul.a_sign <= s1.a_sign;
      tag_mul.a_zero <= s1.a_zero;
      tag_mul.b_zero <= (s1.mb == '0);
      tag_mul.simple <= s1.simple;
      tag_mul.prod   <= 64'(s1.ma) * 64'(s1.mb);
    end
  end

  logic [31:0] ma_d, mb_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      ma_d <= s1.ma;
      mb_d <= (s1.mb == '0) ? 32'd1 : s1.mb;
    end
  end

  assign num    = NW'(ma_d) << FRACTION_BITS;
  assign tag_in = tag_mul;

  // The divider keeps its own resettable valid chain next to the tag.
  fpa_div_pipe #(.NW(NW), .DW(32), .TW($bits(tag_t))) u_div (
    .clk(clk), .rst(rst), .en(adv), .v_in(tag_mul.v), .num(num), .den(mb_d),
    .tag_in(tag_in), .quo(quo), .rem(rem), .den_out(den_out), .v_out(div_v),
    .tag_out(tag_out)
  );

  // Rounding stage: magnitude of the result before sign and saturation.
  logic        s3_v;
  tag_t        s3_tag;
  logic [64:0] s3_mag;
  logic [64:0] mag_next;

  always_comb begin
    logic [63:0] pq;
    logic        rb;
    pq = tag_out.prod >> FRACTION_BITS;
    rb = (FRACTION_BITS > 0) ? tag_out.prod[(FRACTION_BITS > 0) ? FRACTION_BITS-1 : 0]
                             : 1'b0;
    if (op_t'(tag_out.op) == OP_MUL)
      mag_next = {1'b0, pq} + 65'(rb);
    else
      mag_next = 65'(quo) + 65'({rem, 1'b0} >= {2'b00, den_out});
  end

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= div_v;
    if (adv) begin
      s3_tag <= tag_out;
      s3_mag <= mag_next;
    end
  end

  // Final stage: sign, saturation and result select.
  result_t fin;
  always_comb begin
    fin = '0;
    case (op_t'(s3_tag.op))
      OP_MUL, OP_DIV: begin
        if (op_t'(s3_tag.op) == OP_DIV && s3_tag.b_zero) begin
          fin.div_by_zero = 1'b1;
          if (!s3_tag.a_zero) begin
            fin.overflow = 1'b1;
            fin.value    = s3_tag.a_sign ? VAL_MIN : VAL_MAX;
          end
        end else if (s3_tag.neg) begin
          if (s3_mag > 65'h8000_0000) begin
            fin.overflow = 1'b1; fin.value = VAL_MIN;
          end else begin
            fin.value = 32'(-s3_mag[31:0]);
          end
        end else begin
          if (s3_mag > 65'h7FFF_FFFF) begin
            fin.overflow = 1'b1; fin.value = VAL_MAX;
          end else begin
            fin.value = s3_mag[31:0];
          end
        end
      end
      default: fin = s3_tag.simple;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= s3_v;
    if (adv) out_reg <= fin;
  end

  assign res.valid       = out_valid;
  assign res.value       = out_reg.value;
  assign res.less        = out_reg.less;
  assign res.equal       = out_reg.equal;
  assign res.greater     = out_reg.greater;
  assign res.overflow    = out_reg.overflow;
  assign res.div_by_zero = out_reg.div_by_zero;

  // A stalled result must hold until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.ready |=> out_valid && $stable(out_reg))
    else $error("result changed while stalled");
  // Compare sets exactly one relation flag.
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_reg.less || out_reg.equal || out_reg.greater) |->
    $onehot({out_reg.less, out_reg.equal, out_reg.greater}))
    else $error("compare flags not one-hot");
  // Ready is high whenever the output register is empty.
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> req.ready)
    else $error("ready low with empty output");
  // Division by zero only on a nonzero-free value path: 0/0 gives 0.
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.div_by_zero && !out_reg.overflow |-> out_reg.value == '0)
    else $error("0/0 not zero");

endmodule
